@@ rtl/snfc_pkg.sv @@
// Shared types and constants of the SPI NOR flash command sequencer.
`default_nettype none
package snfc_pkg;

  typedef enum logic [2:0] {
    CMD_ID90   = 3'd0,
    CMD_ID9F   = 3'd1,
    CMD_ERASE  = 3'd2,
    CMD_WRITE  = 3'd3,
    CMD_READ   = 3'd4,
    CMD_WDATA  = 3'd5,
    CMD_RXBYTE = 3'd6,
    CMD_UNUSED = 3'd7
  } cmd_e;

  typedef enum logic [2:0] {
    K_XFER   = 3'd0,
    K_DESEL  = 3'd1,
    K_RDBYTE = 3'd2,
    K_ID     = 3'd3,
    K_DREQ   = 3'd4,
    K_DONE   = 3'd5
  } kind_e;

  typedef enum logic [3:0] {
    PH_IDLE, PH_WREN, PH_CMD, PH_ADDR_HI, PH_ADDR_MID, PH_ADDR_LO,
    PH_ID_RX, PH_READ_RX, PH_WAIT_DATA, PH_PROG_RX, PH_RDSR, PH_POLL
  } phase_e;

  localparam logic [7:0] OPC_ID90  = 8'h90;
  localparam logic [7:0] OPC_ID9F  = 8'h9F;
  localparam logic [7:0] OPC_WREN  = 8'h06;
  localparam logic [7:0] OPC_SE    = 8'h20;
  localparam logic [7:0] OPC_PP    = 8'h02;
  localparam logic [7:0] OPC_READ  = 8'h03;
  localparam logic [7:0] OPC_RDSR  = 8'h05;
  localparam logic [7:0] FILLER_RESET = 8'h5F;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [23:0] address;
    logic [15:0] length;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [23:0] value;
    logic        last;
  } out_item_t;

  // Up to three results from one beat.
  typedef struct packed {
    logic [1:0]   count;
    out_item_t [2:0] res;
  } res_group_t;

endpackage
`default_nettype wire

@@ rtl/snfc_engine.sv @@
// Sequencer state and the result group produced for each accepted beat.
`default_nettype none
module snfc_engine import snfc_pkg::*; #(
  parameter int unsigned PAGE_SIZE = 256
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [7:0] filler_i,
  input  wire logic       valid_i,
  output logic            ready_o,
  input  wire in_item_t   item_i,
  output logic            grp_valid_o,
  input  wire logic       grp_ready_i,
  output res_group_t      grp_o
);
  localparam int unsigned PW = $clog2(PAGE_SIZE);

  phase_e      phase_q, phase_d;
  logic [2:0]  op_q, op_d;
  logic [23:0] addr_q, addr_d;
  logic [15:0] rem_q, rem_d;
  logic [12:0] seg_q, seg_d;
  logic [23:0] id_q, id_d;
  logic        gv_q;
  res_group_t  g_q, g_d;
  logic        fire;

  assign ready_o     = !gv_q || grp_ready_i;
  assign fire        = valid_i && ready_o;
  assign grp_valid_o = gv_q;
  assign grp_o       = g_q;

  // Split remaining bytes at the next page boundary.
  function automatic void page_split(input logic [23:0] a, input logic [15:0] r,
                                     output logic [12:0] s, output logic [15:0] rn);
    logic [16:0] room;
    room = 17'(PAGE_SIZE) - 17'(a[PW-1:0]);
    if ({1'b0, r} < room) s = 13'(r);
    else s = 13'(room);
    rn = r - 16'(s);
  endfunction

  // Compute next state and results.
  always_comb begin
    logic [1:0] n;
    out_item_t [2:0] r;
    logic [12:0] s;
    logic [15:0] rn;
    n = '0;
    r = '0;
    s = '0;
    rn = '0;
    phase_d = phase_q; op_d = op_q; addr_d = addr_q; rem_d = rem_q;
    seg_d = seg_q; id_d = id_q;
    case (item_i.cmd)
      CMD_ID90, CMD_ID9F, CMD_ERASE, CMD_WRITE, CMD_READ: begin
        if (phase_q == PH_IDLE) begin
          op_d = item_i.cmd; addr_d = item_i.address; rem_d = item_i.length;
          seg_d = '0; id_d = '0; n = 2'd1;
          case (item_i.cmd)
            CMD_ID90: begin
              addr_d = '0; r[0] = '{K_XFER, 24'(OPC_ID90), 1'b0}; phase_d = PH_CMD;
            end
            CMD_ID9F: begin
              r[0] = '{K_XFER, 24'(OPC_ID9F), 1'b0}; phase_d = PH_CMD;
            end
            CMD_ERASE: begin
              r[0] = '{K_XFER, 24'(OPC_WREN), 1'b0}; phase_d = PH_WREN;
            end
            CMD_WRITE: begin
              if (item_i.length == '0) begin
                r[0] = '{K_DONE, 24'd0, 1'b0}; phase_d = PH_IDLE;
              end else begin
                page_split(item_i.address, item_i.length, s, rn);
                seg_d = s; rem_d = rn;
                r[0] = '{K_XFER, 24'(OPC_WREN), 1'b0}; phase_d = PH_WREN;
              end
            end
            default: begin
              r[0] = '{K_XFER, 24'(OPC_READ), 1'b0}; phase_d = PH_CMD;
            end
          endcase
        end
      end
      CMD_WDATA: begin
        if (phase_q == PH_WAIT_DATA) begin
          n = 2'd1; r[0] = '{K_XFER, 24'(item_i.data_byte), 1'b0};
          phase_d = PH_PROG_RX;
        end
      end
      CMD_RXBYTE: begin
        case (phase_q)
          PH_WREN: begin
            n = 2'd2; r[0] = '{K_DESEL, 24'd0, 1'b0};
            r[1] = '{K_XFER, 24'((op_q == CMD_ERASE) ? OPC_SE : OPC_PP), 1'b0};
            phase_d = PH_CMD;
          end
          PH_CMD: begin
            n = 2'd1;
            if (op_q == CMD_ID9F) begin
              seg_d = 13'd3; r[0] = '{K_XFER, 24'(filler_i), 1'b0}; phase_d = PH_ID_RX;
            end else begin
              r[0] = '{K_XFER, 24'(addr_q[23:16]), 1'b0}; phase_d = PH_ADDR_HI;
            end
          end
          PH_ADDR_HI: begin
            n = 2'd1; r[0] = '{K_XFER, 24'(addr_q[15:8]), 1'b0}; phase_d = PH_ADDR_MID;
          end
          PH_ADDR_MID: begin
            n = 2'd1; r[0] = '{K_XFER, 24'(addr_q[7:0]), 1'b0}; phase_d = PH_ADDR_LO;
          end
          PH_ADDR_LO: begin
            if (op_q == CMD_ID90) begin
              n = 2'd1; seg_d = 13'd2; r[0] = '{K_XFER, 24'(filler_i), 1'b0};
              phase_d = PH_ID_RX;
            end else if (op_q == CMD_ERASE) begin
              n = 2'd2; r[0] = '{K_DESEL, 24'd0, 1'b0};
              r[1] = '{K_XFER, 24'(OPC_RDSR), 1'b0}; phase_d = PH_RDSR;
            end else if (op_q == CMD_WRITE) begin
              n = 2'd1; r[0] = '{K_DREQ, 24'd0, 1'b0}; phase_d = PH_WAIT_DATA;
            end else if (rem_q == '0) begin
              n = 2'd2; r[0] = '{K_DESEL, 24'd0, 1'b0};
              r[1] = '{K_DONE, 24'd0, 1'b0}; phase_d = PH_IDLE;
            end else begin
              n = 2'd1; r[0] = '{K_XFER, 24'(filler_i), 1'b0}; phase_d = PH_READ_RX;
            end
          end
          PH_ID_RX: begin
            id_d = {id_q[15:0], item_i.data_byte};
            seg_d = seg_q - 13'd1;
            if (seg_d != '0) begin
              n = 2'd1; r[0] = '{K_XFER, 24'(filler_i), 1'b0};
            end else begin
              n = 2'd2; r[0] = '{K_DESEL, 24'd0, 1'b0};
              r[1] = '{K_ID, id_d, 1'b0}; phase_d = PH_IDLE;
            end
          end
          PH_READ_RX: begin
            r[0] = '{K_RDBYTE, 24'(item_i.data_byte), 1'b0};
            rem_d = rem_q - 16'd1; addr_d = addr_q + 24'd1;
            if (rem_d != '0) begin
              n = 2'd2; r[1] = '{K_XFER, 24'(filler_i), 1'b0};
            end else begin
              n = 2'd3; r[1] = '{K_DESEL, 24'd0, 1'b0};
              r[2] = '{K_DONE, 24'd0, 1'b0}; phase_d = PH_IDLE;
            end
          end
          PH_PROG_RX: begin
            seg_d = seg_q - 13'd1; addr_d = addr_q + 24'd1;
            if (seg_d != '0) begin
              n = 2'd1; r[0] = '{K_DREQ, 24'd0, 1'b0}; phase_d = PH_WAIT_DATA;
            end else begin
              n = 2'd2; r[0] = '{K_DESEL, 24'd0, 1'b0};
              r[1] = '{K_XFER, 24'(OPC_RDSR), 1'b0}; phase_d = PH_RDSR;
            end
          end
          PH_RDSR: begin
            n = 2'd1; r[0] = '{K_XFER, 24'(filler_i), 1'b0}; phase_d = PH_POLL;
          end
          PH_POLL: begin
            if (item_i.data_byte[0]) begin
              n = 2'd1; r[0] = '{K_XFER, 24'(filler_i), 1'b0};
            end else begin
              n = 2'd2; r[0] = '{K_DESEL, 24'd0, 1'b0};
              if (op_q == CMD_WRITE && rem_q != '0) begin
                page_split(addr_q, rem_q, s, rn);
                seg_d = s; rem_d = rn;
                r[1] = '{K_XFER, 24'(OPC_WREN), 1'b0}; phase_d = PH_WREN;
              end else begin
                r[1] = '{K_DONE, 24'd0, 1'b0}; phase_d = PH_IDLE;
              end
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    // Mark the final result of the group.
    case (n)
      2'd1: r[0].last = 1'b1;
      2'd2: r[1].last = 1'b1;
      2'd3: r[2].last = 1'b1;
      default: ;
    endcase
    g_d.count = n;
    g_d.res   = r;
  end

  // Advance state on each accepted beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE; op_q <= '0; addr_q <= '0; rem_q <= '0;
      seg_q <= '0; id_q <= '0; gv_q <= 1'b0;
    end else begin
      if (fire) begin
        phase_q <= phase_d; op_q <= op_d; addr_q <= addr_d; rem_q <= rem_d;
        seg_q <= seg_d; id_q <= id_d;
        gv_q <= (g_d.count != '0);
      end else if (grp_ready_i) begin
        gv_q <= 1'b0;
      end
    end
  end

  // Hold the result group until the emitter takes it.
  always_ff @(posedge clk_i) begin
    if (fire) g_q <= g_d;
  end
endmodule
`default_nettype wire

@@ rtl/snfc_emitter.sv @@
// Queue of result groups and serializer that sends one result per beat.
`default_nettype none
module snfc_emitter import snfc_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       grp_valid_i,
  output logic            grp_ready_o,
  input  wire res_group_t grp_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output out_item_t       out_item_o
);
  res_group_t  mem_q [2];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;
  logic [1:0]  idx_q;
  logic        push, pop;
  res_group_t  head;

  assign head        = mem_q[rp_q];
  assign grp_ready_o = (cnt_q != 2'd2);
  assign push        = grp_valid_i && grp_ready_o;
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_item_o  = head.res[idx_q];
  assign pop         = out_valid_o && out_ready_i && (idx_q == head.count - 2'd1);

  // Track fill level and read position.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0; idx_q <= '0;
    end else begin
      if (push) wp_q <= !wp_q;
      if (pop) begin
        rp_q <= !rp_q; idx_q <= '0;
      end else if (out_valid_o && out_ready_i) begin
        idx_q <= idx_q + 2'd1;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  // Store incoming groups.
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= grp_i;
  end
endmodule
`default_nettype wire

@@ rtl/spi_nor_flash_command_sequencer.sv @@
// SPI NOR flash command sequencer: top level.
// A beat's results are registered in the engine's group register and then in
// the emitter's two-group queue before they reach the output. The sequencer
// takes one input beat per cycle while its group register is empty or being
// taken; results leave one per cycle while out_ready_i is high, so a beat that
// makes two or three results holds the input side once the queue is full.
// Reset: asynchronous active low; sequencer idle, filler byte 0x5F.
`default_nettype none
module spi_nor_flash_command_sequencer import snfc_pkg::*; #(
  parameter int unsigned PAGE_SIZE = 256
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire in_item_t   in_item_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output out_item_t       out_item_o
);
  logic [7:0] filler_q;
  logic       gv, gr;
  res_group_t grp;

  // Hold the filler byte register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) filler_q <= FILLER_RESET;
    else if (cfg_we_i) filler_q <= cfg_wdata_i;
  end

  snfc_engine #(.PAGE_SIZE(PAGE_SIZE)) u_engine (
    .clk_i, .rst_ni, .filler_i(filler_q), .valid_i(in_valid_i),
    .ready_o(in_ready_o), .item_i(in_item_i),
    .grp_valid_o(gv), .grp_ready_i(gr), .grp_o(grp)
  );

  snfc_emitter u_emitter (
    .clk_i, .rst_ni, .grp_valid_i(gv), .grp_ready_o(gr), .grp_i(grp),
    .out_valid_o, .out_ready_i, .out_item_o
  );
endmodule
`default_nettype wire
